>>> hdl/assert_macros.svh
// Assertion helpers included by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/srrs_pkg.sv
package srrs_pkg;

    localparam int QueueDepth  = 16;
    localparam int DeviceCount = 4;
    localparam int QIdxW       = $clog2(QueueDepth);
    localparam int CntW        = $clog2(QueueDepth + 1);
    localparam int DevW        = 2;

    localparam logic [2:0] KIND_ADMIT    = 3'd0;
    localparam logic [2:0] KIND_REQUEUE  = 3'd1;
    localparam logic [2:0] KIND_BLOCK    = 3'd2;
    localparam logic [2:0] KIND_RELEASE  = 3'd3;
    localparam logic [2:0] KIND_DISPATCH = 3'd4;

    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_DISPATCHED = 3'd1;
    localparam logic [2:0] ST_NONE       = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_DEV_EMPTY  = 3'd4;
    localparam logic [2:0] ST_RELEASED   = 3'd5;

    // Operations the controller commands the datapath to perform.
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_PUSH_W    = 3'd1;
    localparam logic [2:0] OP_PUSH_A    = 3'd2;
    localparam logic [2:0] OP_PUSH_B    = 3'd3;
    localparam logic [2:0] OP_RELEASE   = 3'd4;
    localparam logic [2:0] OP_DISPATCH  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       move;
    } srrs_cmd_t;

    typedef struct packed {
        logic w_empty;
        logic w_full;
        logic a_empty;
        logic a_full;
        logic b_empty;
        logic b_full;
        logic move_ok;
    } srrs_stat_t;

    // Add an unsigned rate to a signed priority, saturating at the top.
    function automatic logic signed [15:0] age_sat(logic signed [15:0] p,
                                                   logic [7:0] r);
        logic signed [17:0] s;
        s = 18'(p) + $signed({10'd0, r});
        age_sat = (s > 18'sd32767) ? 16'sh7fff : s[15:0];
    endfunction

endpackage

>>> hdl/srrs_datapath.sv
module srrs_datapath
    import srrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [7:0]         task_id,
    input  logic signed [15:0] priority_req,
    input  logic [DevW-1:0]    device,
    input  logic [7:0]         w_rate,
    input  logic [7:0]         a_rate,
    input  srrs_cmd_t          cmd,
    output srrs_stat_t         stat,
    output logic [7:0]         head_id,
    output logic signed [15:0] head_prio
);

    // Captured item fields.
    logic [7:0]         id_reg;
    logic signed [15:0] prio_reg;
    logic [DevW-1:0]    dev_reg;

    logic [7:0]         w_id_reg [QueueDepth];
    logic signed [15:0] w_pr_reg [QueueDepth];
    logic [7:0]         a_id_reg [QueueDepth];
    logic signed [15:0] a_pr_reg [QueueDepth];
    logic [CntW-1:0]    w_cnt_reg, a_cnt_reg;
    logic [CntW-1:0]    b_cnt_reg [DeviceCount];

    // Blocked queues share one memory; each device owns a circular slice of it.
    logic [23:0]        b_mem [DeviceCount * QueueDepth];
    logic [QIdxW-1:0]   b_head_reg [DeviceCount];
    logic [23:0]        b_rd_reg;

    logic [CntW-1:0]    b_cnt;
    logic [QIdxW-1:0]   b_wr_ptr;
    logic [QIdxW-1:0]   a_tail;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg   <= task_id;
            prio_reg <= priority_req;
            dev_reg  <= device;
        end
    end

    // Blocked memory: the head of the addressed device is read when a word is taken,
    // so it is ready while the word executes.
    always_ff @(posedge clk)
    begin
        if (load)
            b_rd_reg <= b_mem[{device, b_head_reg[device]}];
        if (cmd.op == OP_PUSH_B)
            b_mem[{dev_reg, b_wr_ptr}] <= {id_reg, prio_reg};
    end

    // Status decoded from counts.
    always_comb
    begin
        b_cnt        = b_cnt_reg[dev_reg];
        b_wr_ptr     = b_head_reg[dev_reg] + QIdxW'(b_cnt);
        a_tail       = QIdxW'(a_cnt_reg - CntW'(1));
        stat.w_empty = (w_cnt_reg == '0);
        stat.w_full  = (w_cnt_reg == CntW'(QueueDepth));
        stat.a_empty = (a_cnt_reg == '0);
        stat.a_full  = (a_cnt_reg == CntW'(QueueDepth));
        stat.b_empty = (b_cnt == '0);
        stat.b_full  = (b_cnt == CntW'(QueueDepth));
        stat.move_ok = !stat.w_empty && !stat.a_full &&
                       (stat.a_empty || (w_pr_reg[0] >= a_pr_reg[a_tail]));
    end

    // Queue updates. Dispatch is done in two steps: move/age, then pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cnt_reg <= '0;
            a_cnt_reg <= '0;
            for (int d = 0; d < DeviceCount; d++)
            begin
                b_cnt_reg[d]  <= '0;
                b_head_reg[d] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_PUSH_W:
                begin
                    w_id_reg[QIdxW'(w_cnt_reg)] <= id_reg;
                    w_pr_reg[QIdxW'(w_cnt_reg)] <= prio_reg;
                    w_cnt_reg <= w_cnt_reg + CntW'(1);
                end
                OP_PUSH_A:
                begin
                    a_id_reg[QIdxW'(a_cnt_reg)] <= id_reg;
                    a_pr_reg[QIdxW'(a_cnt_reg)] <= prio_reg;
                    a_cnt_reg <= a_cnt_reg + CntW'(1);
                end
                OP_PUSH_B:
                begin
                    b_cnt_reg[dev_reg] <= b_cnt + CntW'(1);
                end
                OP_RELEASE:
                begin
                    a_id_reg[QIdxW'(a_cnt_reg)] <= b_rd_reg[23:16];
                    a_pr_reg[QIdxW'(a_cnt_reg)] <= $signed(b_rd_reg[15:0]);
                    a_cnt_reg <= a_cnt_reg + CntW'(1);
                    b_head_reg[dev_reg] <= b_head_reg[dev_reg] + QIdxW'(1);
                    b_cnt_reg[dev_reg] <= b_cnt - CntW'(1);
                end
                OP_DISPATCH:
                begin
                    if (cmd.move)
                    begin
                        // Waiting head moves to the accepted tail; all shift.
                        for (int i = 0; i < QueueDepth - 1; i++)
                        begin
                            w_id_reg[i] <= w_id_reg[i+1];
                            w_pr_reg[i] <= age_sat(w_pr_reg[i+1], w_rate);
                        end
                        for (int i = 0; i < QueueDepth; i++)
                            a_pr_reg[i] <= age_sat(a_pr_reg[i], a_rate);
                        a_id_reg[QIdxW'(a_cnt_reg)] <= w_id_reg[0];
                        a_pr_reg[QIdxW'(a_cnt_reg)] <=
                            age_sat(w_pr_reg[0], a_rate);
                        w_cnt_reg <= w_cnt_reg - CntW'(1);
                        a_cnt_reg <= a_cnt_reg + CntW'(1);
                    end
                    else
                    begin
                        for (int i = 0; i < QueueDepth; i++)
                        begin
                            w_pr_reg[i] <= age_sat(w_pr_reg[i], w_rate);
                            a_pr_reg[i] <= age_sat(a_pr_reg[i], a_rate);
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Pop of the accepted head, second step of a dispatch.
            if (cmd.op == OP_NONE && cmd.move && !stat.a_empty)
            begin
                for (int i = 0; i < QueueDepth - 1; i++)
                begin
                    a_id_reg[i] <= a_id_reg[i+1];
                    a_pr_reg[i] <= a_pr_reg[i+1];
                end
                a_cnt_reg <= a_cnt_reg - CntW'(1);
            end
        end
    end

    assign head_id   = (cmd.op == OP_RELEASE) ? b_rd_reg[23:16] : a_id_reg[0];
    assign head_prio = (cmd.op == OP_RELEASE) ? $signed(b_rd_reg[15:0]) : a_pr_reg[0];

endmodule

>>> hdl/srrs_ctrl.sv
`include "assert_macros.svh"

module srrs_ctrl
    import srrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         kind,
    input  logic [DevW-1:0]    device,
    input  srrs_stat_t         stat,
    input  logic [7:0]         head_id,
    input  logic signed [15:0] head_prio,
    output logic               busy,
    output logic               load,
    output srrs_cmd_t          cmd,
    output logic               done,
    output logic [2:0]         status,
    output logic [7:0]         out_task_id,
    output logic signed [15:0] out_priority
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [2:0]         kind_reg;
    logic               dev_ok_reg;
    logic               done_reg, done_next;
    logic [2:0]         st_reg, st_next;
    logic [7:0]         id_reg, id_next;
    logic signed [15:0] pr_reg, pr_next;

    assign busy = (state_reg != S_IDLE);
    assign load = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        id_next    = 8'd0;
        pr_next    = 16'sd0;
        cmd.op     = OP_NONE;
        cmd.move   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (load)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                st_next    = ST_NONE;
                case (kind_reg)
                    KIND_ADMIT:
                    begin
                        st_next = stat.w_full ? ST_FULL : ST_QUEUED;
                        if (!stat.w_full)
                            cmd.op = OP_PUSH_W;
                    end
                    KIND_REQUEUE:
                    begin
                        st_next = stat.a_full ? ST_FULL : ST_QUEUED;
                        if (!stat.a_full)
                            cmd.op = OP_PUSH_A;
                    end
                    KIND_BLOCK:
                    begin
                        if (!dev_ok_reg || stat.b_full)
                            st_next = ST_FULL;
                        else
                        begin
                            st_next = ST_QUEUED;
                            cmd.op  = OP_PUSH_B;
                        end
                    end
                    KIND_RELEASE:
                    begin
                        if (!dev_ok_reg || stat.b_empty)
                            st_next = ST_DEV_EMPTY;
                        else if (stat.a_full)
                            st_next = ST_FULL;
                        else
                        begin
                            st_next = ST_RELEASED;
                            cmd.op  = OP_RELEASE;
                            id_next = head_id;
                            pr_next = head_prio;
                        end
                    end
                    KIND_DISPATCH:
                    begin
                        cmd.op     = OP_DISPATCH;
                        cmd.move   = stat.move_ok;
                        state_next = S_POP;
                        done_next  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP:
            begin
                cmd.move   = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
                st_next    = stat.a_empty ? ST_NONE : ST_DISPATCHED;
                if (!stat.a_empty)
                begin
                    id_next = head_id;
                    pr_next = head_prio;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind;
            dev_ok_reg <= (32'(device) < DeviceCount);
        end
        if (done_next)
        begin
            st_reg <= st_next;
            id_reg <= id_next;
            pr_reg <= pr_next;
        end
    end

    assign done         = done_reg;
    assign status       = st_reg;
    assign out_task_id  = id_reg;
    assign out_priority = pr_reg;

    `ASSERT_IMPL(a_no_start_busy, clk, rst_n, (load |=> busy), "accepted word not taken")
    `ASSERT_IMPL(a_pop_follows, clk, rst_n, (state_reg == S_POP |=> done), "dispatch gave no word")
    `ASSERT_NEVER(a_done_busy, clk, rst_n, (done && state_reg == S_POP), "result during pop")

endmodule

>>> hdl/selfish_round_robin_scheduler_core.sv
// Each word is taken while idle, executes in S_EXEC and then sets the registered done;
// dispatch runs S_EXEC (move/age), then S_POP (pop). busy holds off start until done.
// The controller sequences each word through the queue register file.
// Reset (rst_n low, async) empties all queues and restores both aging rates.
// The result strobe done is high for one cycle; the receiver cannot stall.
module selfish_round_robin_scheduler_core
    import srrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic [7:0]         task_id,
    input  logic signed [15:0] priority_req,
    input  logic [1:0]         device,
    output logic               done,
    output logic [2:0]         status,
    output logic [7:0]         out_task_id,
    output logic signed [15:0] out_priority,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0]         w_rate_reg, a_rate_reg;
    logic               load;
    srrs_cmd_t          cmd;
    srrs_stat_t         stat;
    logic [7:0]         head_id;
    logic signed [15:0] head_prio;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_rate_reg <= 8'd2;
            a_rate_reg <= 8'd1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 3'd0)
                w_rate_reg <= pwdata[7:0];
            else if (paddr == 3'd4)
                a_rate_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        case (paddr)
            3'd0:    prdata = {24'd0, w_rate_reg};
            3'd4:    prdata = {24'd0, a_rate_reg};
            default: prdata = 32'd0;
        endcase
    end

    srrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(kind), .device(device),
        .stat(stat), .head_id(head_id), .head_prio(head_prio), .busy(busy),
        .load(load), .cmd(cmd), .done(done), .status(status),
        .out_task_id(out_task_id), .out_priority(out_priority)
    );

    srrs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load(load), .task_id(task_id),
        .priority_req(priority_req), .device(device), .w_rate(w_rate_reg),
        .a_rate(a_rate_reg), .cmd(cmd), .stat(stat), .head_id(head_id),
        .head_prio(head_prio)
    );

endmodule
